[rtl/tbdp_pkg.sv]
// shared types and constants of the tiled bitmap disc painter
// used by the top level; depends on nothing
package tbdp_pkg;

  // storage geometry
  localparam int unsigned MAP_BITS = 1048576;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WORD_AW  = $clog2(WORD_W);
  localparam int unsigned RAM_DEPTH = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned RAM_AW   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // datapath widths
  localparam int unsigned COORD_W = 13;
  localparam int unsigned RW_W    = 11;
  localparam int unsigned ACR_W   = 7;
  localparam int unsigned REG_W   = 22;
  localparam int unsigned SUB_W   = 23;
  localparam int unsigned ADDR_W  = 44;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned DIV_CW  = 4;
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(COORD_W - 1);

  // opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PAINT = 2'd2;

  // register indexes
  localparam logic [1:0] REG_RW  = 2'd0;
  localparam logic [1:0] REG_ACR = 2'd1;
  localparam logic [1:0] REG_MW  = 2'd2;
  localparam logic [1:0] REG_MH  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
    logic        write_value;
    logic [7:0]  radius_px;
  } in_item_t;

  typedef struct packed {
    logic             read_bit;
    logic             status;
    logic [CNT_W-1:0] painted_count;
  } out_item_t;

endpackage

[rtl/tbdp_ram.sv]
// generic single-port ram with registered read
// no dependencies
module tbdp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/tiled_bitmap_disc_painter_top.sv]
// top level of the tiled bitmap disc painter: sequencer, divider, bit store
// depends on tbdp_pkg and tbdp_ram

// One item is handled at a time. After reset the store is swept to zero, one
// 32-bit word per cycle (MAP_BITS/32 = 32768 words), and no item is taken
// until the sweep ends. A read or write takes two 13-step passes of the shared
// restoring divider (x and y by the region width), the multiply states for
// the bit address, then a read-modify-write of one ram word. A disc paint
// tests each pixel of its clamped square and steps on; each pixel inside the
// disc also runs the divider, multiply and update path. The result register
// frees the input side as soon as a result is loaded.
module tiled_bitmap_disc_painter_top
  import tbdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TEST  = 4'd2;
  localparam logic [3:0] S_DIVX  = 4'd3;
  localparam logic [3:0] S_DIVY  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_RMW   = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [ADDR_W-1:0] MAP_LIMIT = ADDR_W'(MAP_BITS);
  localparam logic [RAM_AW-1:0] CLR_LAST  = RAM_AW'(RAM_DEPTH - 1);

  // configuration registers
  logic [RW_W-1:0]    rw_q;
  logic [ACR_W-1:0]   acr_q;
  logic [COORD_W-1:0] mw_q, mh_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q  <= RW_W'(256);
      acr_q <= ACR_W'(4);
      mw_q  <= COORD_W'(1024);
      mh_q  <= COORD_W'(1024);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_RW:  rw_q  <= pwdata[RW_W-1:0];
        REG_ACR: acr_q <= pwdata[ACR_W-1:0];
        REG_MW:  mw_q  <= pwdata[COORD_W-1:0];
        REG_MH:  mh_q  <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_RW:  prdata = 32'(rw_q);
      REG_ACR: prdata = 32'(acr_q);
      REG_MW:  prdata = 32'(mw_q);
      REG_MH:  prdata = 32'(mh_q);
      default: prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  logic [3:0]         state_q, state_d;
  logic [RAM_AW-1:0]  clr_q, clr_d;
  logic [1:0]         op_q, op_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic               val_q, val_d;
  logic [15:0]        r2_q, r2_d;
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic [COORD_W-1:0] left_q, left_d, right_q, right_d, bot_q, bot_d;
  logic [REG_W-1:0]   rw2_q, rw2_d;
  logic [COORD_W-1:0] num_q, num_d;
  logic [RW_W-1:0]    rem_q, rem_d;
  logic [DIV_CW-1:0]  dcnt_q, dcnt_d;
  logic [COORD_W-1:0] qx_q, qx_d;
  logic [RW_W-1:0]    rx_q, rx_d;
  logic [REG_W-1:0]   reg_q, reg_d;
  logic [SUB_W-1:0]   sub_q, sub_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic               rd_q, rd_d, st_q, st_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  // ram port
  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  tbdp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // accept-time bounds of the paint square
  logic [COORD_W-1:0] in_x, in_y, in_r, xr, yr, wlim, hlim, left_c, top_c, right_c, bot_c;
  assign in_x    = COORD_W'(in_item_i.x_coord);
  assign in_y    = COORD_W'(in_item_i.y_coord);
  assign in_r    = COORD_W'(in_item_i.radius_px);
  assign xr      = in_x + in_r;
  assign yr      = in_y + in_r;
  assign wlim    = mw_q - COORD_W'(2);
  assign hlim    = mh_q - COORD_W'(2);
  assign left_c  = (in_x > in_r) ? in_x - in_r : '0;
  assign top_c   = (in_y > in_r) ? in_y - in_r : '0;
  assign right_c = (xr > wlim) ? wlim : xr;
  assign bot_c   = (yr > hlim) ? hlim : yr;

  // disc membership test
  logic [COORD_W-1:0] dx13, dy13;
  logic [15:0]        dxsq, dysq;
  logic [16:0]        dist2;
  assign dx13  = (px_q > x_q) ? px_q - x_q : x_q - px_q;
  assign dy13  = (py_q > y_q) ? py_q - y_q : y_q - py_q;
  assign dxsq  = 16'(dx13[7:0]) * 16'(dx13[7:0]);
  assign dysq  = 16'(dy13[7:0]) * 16'(dy13[7:0]);
  assign dist2 = 17'(dxsq) + 17'(dysq);

  // one restoring division step
  logic [RW_W:0]      dtrial;
  logic               dbit;
  logic [RW_W-1:0]    rem_n;
  logic [COORD_W-1:0] num_n;
  assign dtrial = {rem_q, num_q[COORD_W-1]};
  assign dbit   = dtrial >= {1'b0, rw_q};
  assign rem_n  = dbit ? RW_W'(dtrial - {1'b0, rw_q}) : dtrial[RW_W-1:0];
  assign num_n  = {num_q[COORD_W-2:0], dbit};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // sequencer
  always_comb begin
    state_d = state_q;  clr_d = clr_q;  op_d = op_q;  x_d = x_q;  y_d = y_q;
    val_d = val_q;  r2_d = r2_q;  px_d = px_q;  py_d = py_q;
    left_d = left_q;  right_d = right_q;  bot_d = bot_q;  rw2_d = rw2_q;
    num_d = num_q;  rem_d = rem_q;  dcnt_d = dcnt_q;  qx_d = qx_q;  rx_d = rx_q;
    reg_d = reg_q;  sub_d = sub_q;  addr_d = addr_q;  rd_d = rd_q;  st_d = st_q;
    cnt_d = cnt_q;  out_valid_d = out_valid_q;  out_d = out_q;
    ram_we = 1'b0;
    ram_addr = addr_q[WORD_AW +: RAM_AW];
    ram_wdata = ram_rdata;
    ram_wdata[addr_q[WORD_AW-1:0]] = val_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + RAM_AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_item_i.opcode;
          x_d    = in_x;
          y_d    = in_y;
          val_d  = in_item_i.write_value;
          r2_d   = 16'(in_item_i.radius_px) * 16'(in_item_i.radius_px);
          rw2_d  = REG_W'(rw_q) * REG_W'(rw_q);
          rd_d   = 1'b0;
          st_d   = 1'b0;
          cnt_d  = '0;
          px_d   = in_x;
          py_d   = in_y;
          num_d  = in_x;
          rem_d  = '0;
          dcnt_d = '0;
          left_d = left_c;
          right_d = right_c;
          bot_d  = bot_c;
          state_d = S_DONE;
          if (in_item_i.opcode == OP_READ || in_item_i.opcode == OP_WRITE) begin
            if (rw_q == '0 || in_x >= mw_q || in_y >= mh_q) begin
              st_d = 1'b1;
            end else begin
              state_d = S_DIVX;
            end
          end else if (in_item_i.opcode == OP_PAINT) begin
            if (rw_q == '0 || in_x > mw_q || in_y > mh_q) begin
              st_d = 1'b1;
            end else if (mw_q >= COORD_W'(2) && mh_q >= COORD_W'(2) &&
                         left_c <= right_c && top_c <= bot_c) begin
              px_d = left_c;
              py_d = top_c;
              state_d = S_TEST;
            end
          end else begin
            st_d = 1'b1;
          end
        end
      end
      S_TEST: begin
        num_d  = px_q;
        rem_d  = '0;
        dcnt_d = '0;
        state_d = ({1'b0, r2_q} > dist2) ? S_DIVX : S_NEXT;
      end
      S_DIVX: begin
        num_d  = num_n;
        rem_d  = rem_n;
        dcnt_d = dcnt_q + DIV_CW'(1);
        if (dcnt_q == DIV_LAST) begin
          qx_d   = num_n;
          rx_d   = rem_n;
          num_d  = py_q;
          rem_d  = '0;
          dcnt_d = '0;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        num_d  = num_n;
        rem_d  = rem_n;
        dcnt_d = dcnt_q + DIV_CW'(1);
        if (dcnt_q == DIV_LAST) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        // num holds the row quotient, rem the row remainder
        reg_d = REG_W'(num_q) * REG_W'(acr_q) + REG_W'(qx_q);
        sub_d = SUB_W'(rem_q) * SUB_W'(rw_q) + SUB_W'(rx_q);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        addr_d = ADDR_W'(reg_q) * ADDR_W'(rw2_q) + ADDR_W'(sub_q);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (addr_q >= MAP_LIMIT) begin
          st_d = 1'b1;
          state_d = (op_q == OP_PAINT) ? S_NEXT : S_DONE;
        end else begin
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        if (op_q == OP_READ) begin
          rd_d = ram_rdata[addr_q[WORD_AW-1:0]];
          state_d = S_DONE;
        end else begin
          ram_we = 1'b1;
          if (op_q == OP_PAINT) begin
            cnt_d = cnt_q + CNT_W'(1);
            state_d = S_NEXT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_NEXT: begin
        state_d = S_TEST;
        if (px_q == right_q) begin
          px_d = left_q;
          py_d = py_q + COORD_W'(1);
          if (py_q == bot_q) begin
            state_d = S_DONE;
          end
        end else begin
          px_d = px_q + COORD_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.read_bit = rd_q;
          out_d.status = st_q;
          out_d.painted_count = cnt_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;  x_q <= x_d;  y_q <= y_d;  val_q <= val_d;  r2_q <= r2_d;
    px_q <= px_d;  py_q <= py_d;  left_q <= left_d;  right_q <= right_d;
    bot_q <= bot_d;  rw2_q <= rw2_d;  num_q <= num_d;  rem_q <= rem_d;
    dcnt_q <= dcnt_d;  qx_q <= qx_d;  rx_q <= rx_d;  reg_q <= reg_d;
    sub_q <= sub_d;  addr_q <= addr_d;  rd_q <= rd_d;  st_q <= st_d;
    cnt_q <= cnt_d;  out_q <= out_d;
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken while busy");

  a_ram_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_RMW))
    else $error("store written outside sweep or update");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.read_bit |->
      !out_item_o.status && out_item_o.painted_count == '0)
    else $error("read bit set with error or paint count");

  a_count_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.painted_count != '0 |-> !out_item_o.read_bit)
    else $error("paint result carries read bit");

endmodule
